// ===== rtl/itpt_pkg.sv =====
`default_nettype none

package itpt_pkg;

  localparam int MAX_FIELD_WIDTH = 64;
  localparam int DIGIT_SLOTS     = 24;
  localparam int PREC_LIMIT      = 60;

  localparam int MAG_W    = 64;
  localparam int CNT_W    = 7;
  localparam int DIG_BITS = DIGIT_SLOTS * 4;
  localparam int NDIG_W   = $clog2(DIGIT_SLOTS + 1);
  localparam int SCAN_W   = $clog2(DIGIT_SLOTS);
  localparam int ITER_W   = $clog2(MAG_W);

  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  localparam logic [16*8-1:0] HEX_UPPER = "0123456789ABCDEF";
  localparam logic [16*8-1:0] HEX_LOWER = "0123456789abcdef";

  typedef struct packed {
    logic       start;
    logic [1:0] radix;
    logic       pop;
  } dig_ctl_t;

  typedef struct packed {
    logic              done;
    logic [NDIG_W-1:0] ndig;
    logic [3:0]        top;
  } dig_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [3:0] pos;
    pos = 4'd15 - d;
    if (upper) begin
      digit_char = HEX_UPPER[pos*8 +: 8];
    end else begin
      digit_char = HEX_LOWER[pos*8 +: 8];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/itpt_digit_unit.sv =====
`default_nettype none

module itpt_digit_unit
  import itpt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dig_ctl_t         ctl_i,
  input  logic [MAG_W-1:0] magnitude_i,
  output dig_stat_t        stat_o
);

  localparam int OCT_BITS = DIGIT_SLOTS * 3;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAG_W - 1);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(DIGIT_SLOTS - 1);

  typedef enum logic [1:0] {U_IDLE, U_DEC, U_SCAN, U_DONE} ustate_e;

  ustate_e             state_q;
  logic [DIG_BITS-1:0] dig_q;
  logic [MAG_W-1:0]    bin_q;
  logic [ITER_W-1:0]   iter_q;
  logic [SCAN_W-1:0]   scan_q;
  logic [NDIG_W-1:0]   ndig_q;

  logic [OCT_BITS-1:0] oct_ext;
  logic [DIG_BITS-1:0] oct_load;
  logic [DIG_BITS-1:0] hex_load;
  logic [DIG_BITS-1:0] adj;
  logic [DIG_BITS-1:0] dabble;
  logic [DIG_BITS-1:0] shift_up;
  logic [3:0]          top;

  assign oct_ext  = {{(OCT_BITS - MAG_W){1'b0}}, magnitude_i};
  assign hex_load = {{(DIG_BITS - MAG_W){1'b0}}, magnitude_i};

  always_comb begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      oct_load[4*i +: 4] = {1'b0, oct_ext[3*i +: 3]};
    end
  end

  // add-3 correction on every BCD digit, then shift one binary bit in
  always_comb begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      if (dig_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = dig_q[4*i +: 4];
      end
    end
  end

  assign dabble   = {adj[DIG_BITS-2:0], bin_q[MAG_W-1]};
  assign top      = dig_q[DIG_BITS-1 -: 4];
  assign shift_up = {dig_q[DIG_BITS-5:0], 4'h0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      dig_q   <= '0;
      bin_q   <= '0;
      iter_q  <= '0;
      scan_q  <= '0;
      ndig_q  <= '0;
    end else if (ctl_i.start) begin
      scan_q <= '0;
      if (ctl_i.radix == RADIX_DEC) begin
        dig_q   <= '0;
        bin_q   <= magnitude_i;
        iter_q  <= '0;
        state_q <= U_DEC;
      end else begin
        dig_q   <= (ctl_i.radix == RADIX_OCT) ? oct_load : hex_load;
        state_q <= U_SCAN;
      end
    end else begin
      case (state_q)
        U_DEC: begin
          dig_q  <= dabble;
          bin_q  <= {bin_q[MAG_W-2:0], 1'b0};
          iter_q <= iter_q + ITER_W'(1);
          if (iter_q == ITER_LAST) begin
            state_q <= U_SCAN;
          end
        end
        U_SCAN: begin
          // align the leading nonzero digit to the top slot
          if (top != 4'd0 || scan_q == SCAN_LAST) begin
            ndig_q  <= NDIG_W'(DIGIT_SLOTS) - NDIG_W'(scan_q);
            state_q <= U_DONE;
          end else begin
            dig_q  <= shift_up;
            scan_q <= scan_q + SCAN_W'(1);
          end
        end
        U_DONE: begin
          if (ctl_i.pop) begin
            dig_q <= shift_up;
          end
        end
        default: begin
          state_q <= U_IDLE;
        end
      endcase
    end
  end

  assign stat_o.done = (state_q == U_DONE);
  assign stat_o.ndig = ndig_q;
  assign stat_o.top  = top;

endmodule

`default_nettype wire

// ===== rtl/integer_to_padded_text.sv =====
// Integer to padded text: one printf-style integer conversion per input item.
//
// Input channel (in_valid_i / in_ready_o) carries one request: magnitude, sign,
// radix, case, field width, precision and the five flags. Output channel
// (out_valid_o / out_ready_i) returns the text one ASCII character per item,
// with last_char_o set on the final character. A request with no text (zero
// value and precision, no sign, width or octal alternate form) returns nothing.
//
// Steps per request: decimal runs a shift-and-add-3 conversion on one shared
// BCD register, while octal and hex load their digits straight into it. A
// digit alignment scan and the layout step follow, and the text then leaves
// at one character per cycle while the receiver is ready. in_ready_o is high
// only between requests; the next request may be taken while the final
// character still sits in the output register.
//
// Reset clears the sequencer and drops any pending output. When the receiver
// stalls, the output register holds its character and emission pauses.
`default_nettype none

module integer_to_padded_text
  import itpt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MAG_W-1:0]  magnitude_i,
  input  logic              negative_i,
  input  logic [1:0]        radix_select_i,
  input  logic              upper_case_i,
  input  logic [6:0]        field_width_i,
  input  logic signed [6:0] precision_i,
  input  logic              left_justify_i,
  input  logic              zero_fill_i,
  input  logic              show_plus_i,
  input  logic              space_sign_i,
  input  logic              alternate_form_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        char_out_o,
  output logic              last_char_o
);

  typedef enum logic [1:0] {T_IDLE, T_CONV, T_PLAN, T_EMIT} tstate_e;

  // text segments in output order
  typedef enum logic [2:0] {
    SEG_LPAD, SEG_SIGN, SEG_PFX, SEG_ZERO, SEG_DIG, SEG_RPAD
  } seg_e;
  localparam int SEG_N = 6;

  tstate_e          state_q;
  seg_e             seg_q;
  logic [CNT_W-1:0] len_q [SEG_N];
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] left_q;

  // request held for the duration of the conversion
  logic       neg_q, upper_q, lj_q, zf_q, plus_q, spc_q, alt_q, mag_zero_q;
  logic [1:0] radix_q;
  logic [6:0] width_q;
  logic       prec_none_q;
  logic [5:0] prec_val_q;

  logic       out_valid_q, last_q;
  logic [7:0] char_q;

  dig_ctl_t  dig_ctl;
  dig_stat_t dig_stat;

  itpt_digit_unit u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (dig_ctl),
    .magnitude_i (magnitude_i),
    .stat_o      (dig_stat)
  );

  logic in_fire, emit_fire;
  assign in_ready_o = (state_q == T_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_fire  = (state_q == T_EMIT) && (!out_valid_q || out_ready_i);

  assign dig_ctl.start = in_fire;
  assign dig_ctl.radix = radix_select_i;
  assign dig_ctl.pop   = emit_fire && (seg_q == SEG_DIG);

  // layout of the text, worked out once the digit count is known
  logic [CNT_W-1:0] ndig_c, prec_c, zprec, content, pad, total;
  logic [1:0]       plen;
  logic             sign_on, zfill;
  logic [7:0]       sign_ch;
  logic [CNT_W-1:0] plan_len [SEG_N];
  seg_e             first_seg, nxt_seg;

  always_comb begin
    // zero value with zero precision prints no digits
    if (mag_zero_q && !prec_none_q && prec_val_q == 6'd0) begin
      ndig_c = '0;
    end else begin
      ndig_c = CNT_W'(dig_stat.ndig);
    end
    prec_c = {1'b0, prec_val_q};
    if (!prec_none_q && prec_c > ndig_c) begin
      zprec = prec_c - ndig_c;
    end else begin
      zprec = '0;
    end

    sign_on = neg_q || plus_q || spc_q;
    if (neg_q) begin
      sign_ch = CH_MINUS;
    end else if (plus_q) begin
      sign_ch = CH_PLUS;
    end else begin
      sign_ch = CH_SPACE;
    end

    plen = 2'd0;
    if (alt_q) begin
      if (radix_q == RADIX_OCT) begin
        // octal gets its leading zero unless the digit text already opens with one
        if (zprec == '0 && !(mag_zero_q && (prec_none_q || prec_val_q != 6'd0))) begin
          plen = 2'd1;
        end
      end else if (radix_q != RADIX_DEC && !mag_zero_q) begin
        plen = 2'd2;
      end
    end

    content = CNT_W'(sign_on) + CNT_W'(plen) + zprec + ndig_c;
    pad     = (width_q > content) ? width_q - content : '0;
    total   = content + pad;
    zfill   = zf_q && !lj_q && prec_none_q;

    plan_len[SEG_LPAD] = (!lj_q && !zfill) ? pad : '0;
    plan_len[SEG_SIGN] = CNT_W'(sign_on);
    plan_len[SEG_PFX]  = CNT_W'(plen);
    plan_len[SEG_ZERO] = zprec + (zfill ? pad : '0);
    plan_len[SEG_DIG]  = ndig_c;
    plan_len[SEG_RPAD] = lj_q ? pad : '0;
  end

  // first nonempty segment, and the next nonempty one after the current
  always_comb begin
    first_seg = SEG_RPAD;
    nxt_seg   = SEG_RPAD;
    for (int j = SEG_N - 1; j >= 0; j--) begin
      if (plan_len[j] != '0) begin
        first_seg = seg_e'(3'(j));
      end
      if (3'(j) > seg_q && len_q[j] != '0) begin
        nxt_seg = seg_e'(3'(j));
      end
    end
  end

  logic [7:0] emit_ch;
  always_comb begin
    case (seg_q)
      SEG_SIGN: emit_ch = sign_ch;
      SEG_PFX: begin
        if (cnt_q == CNT_W'(1) && len_q[SEG_PFX] == CNT_W'(2)) begin
          emit_ch = upper_q ? CH_X_UP : CH_X_LO;
        end else begin
          emit_ch = CH_ZERO;
        end
      end
      SEG_ZERO: emit_ch = CH_ZERO;
      SEG_DIG:  emit_ch = digit_char(dig_stat.top, upper_q);
      default:  emit_ch = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      seg_q       <= SEG_LPAD;
      cnt_q       <= '0;
      left_q      <= '0;
      for (int j = 0; j < SEG_N; j++) begin
        len_q[j] <= '0;
      end
      neg_q       <= 1'b0;
      upper_q     <= 1'b0;
      lj_q        <= 1'b0;
      zf_q        <= 1'b0;
      plus_q      <= 1'b0;
      spc_q       <= 1'b0;
      alt_q       <= 1'b0;
      mag_zero_q  <= 1'b0;
      radix_q     <= RADIX_OCT;
      width_q     <= '0;
      prec_none_q <= 1'b1;
      prec_val_q  <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      char_q      <= '0;
    end else begin
      // load a new character, or drop the one the receiver just took
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (in_fire) begin
            neg_q       <= negative_i;
            upper_q     <= upper_case_i;
            lj_q        <= left_justify_i;
            zf_q        <= zero_fill_i;
            plus_q      <= show_plus_i;
            spc_q       <= space_sign_i;
            alt_q       <= alternate_form_i;
            mag_zero_q  <= (magnitude_i == '0);
            radix_q     <= radix_select_i;
            // saturate width and precision to their limits
            width_q     <= (field_width_i > 7'(MAX_FIELD_WIDTH)) ?
                           7'(MAX_FIELD_WIDTH) : field_width_i;
            prec_none_q <= precision_i[6];
            prec_val_q  <= (precision_i[5:0] > 6'(PREC_LIMIT)) ?
                           6'(PREC_LIMIT) : precision_i[5:0];
            state_q     <= T_CONV;
          end
        end
        T_CONV: begin
          if (dig_stat.done) begin
            state_q <= T_PLAN;
          end
        end
        T_PLAN: begin
          for (int j = 0; j < SEG_N; j++) begin
            len_q[j] <= plan_len[j];
          end
          seg_q  <= first_seg;
          cnt_q  <= plan_len[first_seg];
          left_q <= total;
          // drop a request that produces no text
          state_q <= (total == '0) ? T_IDLE : T_EMIT;
        end
        T_EMIT: begin
          if (emit_fire) begin
            char_q      <= emit_ch;
            last_q      <= (left_q == CNT_W'(1));
            left_q      <= left_q - CNT_W'(1);
            if (left_q == CNT_W'(1)) begin
              state_q <= T_IDLE;
            end else if (cnt_q == CNT_W'(1)) begin
              seg_q <= nxt_seg;
              cnt_q <= len_q[nxt_seg];
            end else begin
              cnt_q <= cnt_q - CNT_W'(1);
            end
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign last_char_o = last_q;

  // digits are only taken once the converter has aligned them
  a_dig_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && seg_q == SEG_DIG) |-> dig_stat.done)
    else $error("digit emitted before conversion finished");

  // a taken request keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready right after accepting a request");

  // emission always has characters left to send
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_EMIT) |-> (left_q != '0))
    else $error("emitting with no characters left");

  // the final character returns the sequencer to idle
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && left_q == CNT_W'(1)) |=> (state_q == T_IDLE && last_char_o))
    else $error("final character did not end the conversion");

endmodule

`default_nettype wire

// ===== dv/integer_to_padded_text_test.sv =====
`default_nettype none

module integer_to_padded_text_test;
  timeunit 1ns;
  timeprecision 1ps;

  import itpt_pkg::*;

  // Flag bits of a request, packed as {left, zero, plus, space, alt}.
  localparam logic [4:0] FLAG_NONE     = 5'b00000;
  localparam logic [4:0] FLAG_LEFT     = 5'b10000;
  localparam logic [4:0] FLAG_ZPAD     = 5'b01000;
  localparam logic [4:0] FLAG_SHOW_POS = 5'b00100;
  localparam logic [4:0] FLAG_BLANK    = 5'b00010;
  localparam logic [4:0] FLAG_ALT      = 5'b00001;

  // Precision code for "no precision given" and the unused radix code.
  localparam logic [6:0] PREC_NONE    = 7'h7F;
  localparam logic [6:0] PREC_MOST_NEG = 7'h40;
  localparam logic [1:0] RADIX_SPARE  = 2'd3;

  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_A_LO = 8'h61;

  localparam logic [63:0] MAG_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 200;     // decimal conversion + scan + a few spare
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [63:0] magnitude;
    logic        negative;
    logic [1:0]  radix;
    logic        upper;
    logic [6:0]  width;
    logic [6:0]  prec;
    logic        left;
    logic        zero;
    logic        plus;
    logic        space;
    logic        alt;
    int          idle_before;   // cycles the sender waits before offering it
    logic        drain_first;   // hold the item until all text has come back
    logic        calm;          // no idling on either side while it runs
  } request_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [MAG_W-1:0]  magnitude_i = '0;
  logic              negative_i = 1'b0;
  logic [1:0]        radix_select_i = RADIX_OCT;
  logic              upper_case_i = 1'b0;
  logic [6:0]        field_width_i = '0;
  logic signed [6:0] precision_i = '0;
  logic              left_justify_i = 1'b0;
  logic              zero_fill_i = 1'b0;
  logic              show_plus_i = 1'b0;
  logic              space_sign_i = 1'b0;
  logic              alternate_form_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        char_out_o;
  logic              last_char_o;

  request_t   pending_requests[$];
  text_char_t expected_text[$];
  request_t   cur_req;

  int  idle_count = 0;
  int  stall_left = 0;
  logic calm_now = 1'b0;
  int  cycle_count = 0;
  int  error_count = 0;
  int  accepted_count = 0;
  int  silent_count = 0;
  int  chars_checked = 0;

  integer_to_padded_text uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .magnitude_i      (magnitude_i),
    .negative_i       (negative_i),
    .radix_select_i   (radix_select_i),
    .upper_case_i     (upper_case_i),
    .field_width_i    (field_width_i),
    .precision_i      (precision_i),
    .left_justify_i   (left_justify_i),
    .zero_fill_i      (zero_fill_i),
    .show_plus_i      (show_plus_i),
    .space_sign_i     (space_sign_i),
    .alternate_form_i (alternate_form_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .char_out_o       (char_out_o),
    .last_char_o      (last_char_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the characters printf would give for one request and queue them.
  function automatic void predict_text(input request_t rq);
    logic [7:0]  digits[$];     // least significant digit first
    logic [7:0]  out_text[$];
    logic [63:0] v;
    logic [3:0]  d;
    logic [7:0]  ch;
    logic [7:0]  sign_char;
    logic        has_sign;
    logic [7:0]  prefix[2];
    int          width, prec, ndig, zprec, zwidth, pad, content, plen, n;
    width = (rq.width > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH : int'(rq.width);
    // Any negative precision code means none given; large ones saturate.
    if (rq.prec[6]) begin
      prec = -1;
    end else begin
      prec = (rq.prec > PREC_LIMIT) ? PREC_LIMIT : int'(rq.prec);
    end

    v = rq.magnitude;
    if (v == 0) begin
      // Zero with zero precision prints no digits at all.
      if (prec != 0) digits.push_back(CH_ZERO);
    end else begin
      while (v != 0 && digits.size() < DIGIT_SLOTS) begin
        case (rq.radix)
          RADIX_OCT: begin
            d = {1'b0, v[2:0]};
            v = v >> 3;
          end
          RADIX_DEC: begin
            d = 4'(v % 64'd10);
            v = v / 64'd10;
          end
          default: begin    // hex, and the spare code behaves as hex
            d = v[3:0];
            v = v >> 4;
          end
        endcase
        if (d < 4'd10) ch = CH_ZERO + 8'(d);
        else ch = (rq.upper ? CH_A_UP : CH_A_LO) + 8'(d) - 8'd10;
        digits.push_back(ch);
      end
    end
    ndig = digits.size();
    zprec = (prec > ndig) ? prec - ndig : 0;

    // Minus beats plus, plus beats space.
    has_sign = 1'b1;
    if (rq.negative) sign_char = CH_MINUS;
    else if (rq.plus) sign_char = CH_PLUS;
    else if (rq.space) sign_char = CH_SPACE;
    else has_sign = 1'b0;

    plen = 0;
    if (rq.alt) begin
      if (rq.radix == RADIX_HEX || rq.radix == RADIX_SPARE) begin
        if (rq.magnitude != 0) begin
          prefix[0] = CH_ZERO;
          prefix[1] = rq.upper ? CH_X_UP : CH_X_LO;
          plen = 2;
        end
      end else if (rq.radix == RADIX_OCT) begin
        // Octal gets a leading zero only if the text does not start with one.
        if (zprec == 0 && (ndig == 0 || digits[ndig-1] != CH_ZERO)) begin
          prefix[0] = CH_ZERO;
          plen = 1;
        end
      end
    end

    content = (has_sign ? 1 : 0) + plen + zprec + ndig;
    pad = (width > content) ? width - content : 0;
    zwidth = 0;
    if (rq.zero && !rq.left && prec < 0) begin
      zwidth = pad;
      pad = 0;
    end

    if (!rq.left) repeat (pad) out_text.push_back(CH_SPACE);
    if (has_sign) out_text.push_back(sign_char);
    for (int i = 0; i < plen; i++) out_text.push_back(prefix[i]);
    repeat (zwidth + zprec) out_text.push_back(CH_ZERO);
    for (int i = ndig - 1; i >= 0; i--) out_text.push_back(digits[i]);
    if (rq.left) repeat (pad) out_text.push_back(CH_SPACE);

    n = (out_text.size() > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH : out_text.size();
    if (n == 0) silent_count++;
    for (int i = 0; i < n; i++) begin
      expected_text.push_back('{ch: out_text[i], last: (i == n - 1)});
    end
  endfunction

  function automatic request_t make_req(input logic [63:0] mag, input logic neg,
                                        input logic [1:0] radix, input logic upper,
                                        input logic [6:0] width, input logic [6:0] prec,
                                        input logic [4:0] flags);
    request_t rq;
    rq.magnitude   = mag;
    rq.negative    = neg;
    rq.radix       = radix;
    rq.upper       = upper;
    rq.width       = width;
    rq.prec        = prec;
    {rq.left, rq.zero, rq.plus, rq.space, rq.alt} = flags;
    rq.idle_before = $urandom_range(0, 5);
    rq.drain_first = 1'b0;
    rq.calm        = 1'b0;
    return rq;
  endfunction

  // Random request: mostly short fields so the run stays quick, with a
  // tail of wide fields, saturating codes and odd precision encodings.
  function automatic request_t random_req();
    request_t rq;
    int pick;
    logic [63:0] mag;
    pick = $urandom_range(0, 99);
    if (pick < 10) mag = '0;
    else if (pick < 25) mag = 64'($urandom_range(1, 999));
    else if (pick < 30) mag = MAG_MAX;
    else mag = {$urandom(), $urandom()} >> $urandom_range(0, 63);
    rq = make_req(mag, 1'($urandom_range(0, 1)), RADIX_OCT, 1'($urandom_range(0, 1)),
                  '0, PREC_NONE, 5'($urandom_range(0, 31)));
    pick = $urandom_range(0, 9);
    rq.radix = (pick < 3) ? RADIX_OCT : (pick < 6) ? RADIX_DEC :
               (pick < 9) ? RADIX_HEX : RADIX_SPARE;
    pick = $urandom_range(0, 99);
    if (pick < 60) rq.width = 7'($urandom_range(0, 12));
    else if (pick < 85) rq.width = 7'($urandom_range(13, 40));
    else if (pick < 95) rq.width = 7'($urandom_range(41, 64));
    else rq.width = 7'($urandom_range(65, 127));
    pick = $urandom_range(0, 99);
    if (pick < 40) rq.prec = PREC_NONE;
    else if (pick < 50) rq.prec = 7'($urandom_range(64, 126));
    else if (pick < 80) rq.prec = 7'($urandom_range(0, 8));
    else if (pick < 95) rq.prec = 7'($urandom_range(9, 60));
    else rq.prec = 7'($urandom_range(61, 63));
    // Favor the zero flag so the width-filling path gets plenty of use.
    if ($urandom_range(0, 3) == 0) rq.zero = 1'b1;
    return rq;
  endfunction

  // Request driver: offer the oldest pending item once its idle gap has
  // run out, hold it until accepted, and predict its text on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    logic slot_free;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      idle_count <= 0;
    end else begin
      slot_free = !in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_text(cur_req);
        accepted_count++;
        slot_free = 1'b1;
      end
      if (slot_free) begin
        if (pending_requests.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_count < pending_requests[0].idle_before) begin
          // Idle before this item.
          in_valid_i <= 1'b0;
          idle_count <= idle_count + 1;
        end else if (pending_requests[0].drain_first && expected_text.size() != 0) begin
          // Hold off until every character of earlier items is back.
          in_valid_i <= 1'b0;
        end else begin
          cur_req = pending_requests.pop_front();
          magnitude_i      <= cur_req.magnitude;
          negative_i       <= cur_req.negative;
          radix_select_i   <= cur_req.radix;
          upper_case_i     <= cur_req.upper;
          field_width_i    <= cur_req.width;
          precision_i      <= cur_req.prec;
          left_justify_i   <= cur_req.left;
          zero_fill_i      <= cur_req.zero;
          show_plus_i      <= cur_req.plus;
          space_sign_i     <= cur_req.space;
          alternate_form_i <= cur_req.alt;
          in_valid_i       <= 1'b1;
          idle_count       <= 0;
          calm_now         <= cur_req.calm;
        end
      end
    end
  end

  // Text monitor: check every accepted character against the oldest
  // expectation, then draw a random stall (none when calm) before the next one.
  always @(posedge clk_i or negedge rst_ni) begin : text_monitor
    text_char_t want;
    int stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (expected_text.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected character %h last %b with nothing pending",
                   char_out_o, last_char_o);
        end
      end else begin
        want = expected_text.pop_front();
        if (char_out_o !== want.ch || last_char_o !== want.last) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch at character %0d: expected %h last %b, got %h last %b",
                     chars_checked, want.ch, want.last, char_out_o, last_char_o);
          end
        end
      end
      chars_checked++;
      stall = calm_now ? 0 : $urandom_range(0, 5);
      out_ready_i <= (stall == 0);
      stall_left  <= stall;
    end else if (!out_ready_i) begin
      // Count down the stall, then raise ready.
      if (stall_left <= 1) begin
        out_ready_i <= 1'b1;
        stall_left  <= 0;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    request_t rq;

    // Directed items: extremes and the special cases.
    // Zero value with zero precision and nothing else: no text at all.
    pending_requests.push_back(make_req('0, 1'b0, RADIX_DEC, 1'b0, 7'd0, 7'd0, FLAG_NONE));
    // Same, but a width still yields padding only.
    pending_requests.push_back(make_req('0, 1'b0, RADIX_DEC, 1'b0, 7'd5, 7'd0, FLAG_NONE));
    // Octal alternate form on zero with zero precision prints one zero.
    pending_requests.push_back(make_req('0, 1'b0, RADIX_OCT, 1'b0, 7'd0, 7'd0, FLAG_ALT));
    // Hex alternate form on zero: no prefix.
    pending_requests.push_back(make_req('0, 1'b0, RADIX_HEX, 1'b1, 7'd0, PREC_NONE, FLAG_ALT));
    // Plus sign alone on zero with zero precision.
    pending_requests.push_back(make_req('0, 1'b0, RADIX_DEC, 1'b0, 7'd0, 7'd0,
                                        FLAG_SHOW_POS));
    // Largest magnitude in every radix.
    pending_requests.push_back(make_req(MAG_MAX, 1'b1, RADIX_DEC, 1'b0, 7'd0, PREC_NONE,
                                        FLAG_NONE));
    pending_requests.push_back(make_req(MAG_MAX, 1'b0, RADIX_OCT, 1'b0, 7'd0, PREC_NONE,
                                        FLAG_ALT));
    pending_requests.push_back(make_req(MAG_MAX, 1'b0, RADIX_HEX, 1'b1, 7'd0, PREC_NONE,
                                        FLAG_ALT | FLAG_SHOW_POS));
    pending_requests.push_back(make_req(MAG_MAX, 1'b0, RADIX_HEX, 1'b0, 7'd0, PREC_NONE,
                                        FLAG_ALT));
    // Alternate form in decimal has no effect.
    pending_requests.push_back(make_req(64'd255, 1'b0, RADIX_DEC, 1'b0, 7'd0, PREC_NONE,
                                        FLAG_ALT));
    // Spare radix code behaves as hex.
    pending_requests.push_back(make_req(64'hDEAD_BEEF, 1'b0, RADIX_SPARE, 1'b1, 7'd0,
                                        PREC_NONE, FLAG_ALT));
    // Width beyond the limit saturates, left and right justified.
    pending_requests.push_back(make_req(64'd42, 1'b0, RADIX_DEC, 1'b0, 7'd127, PREC_NONE,
                                        FLAG_LEFT));
    pending_requests.push_back(make_req(64'd42, 1'b1, RADIX_DEC, 1'b0, 7'd100, PREC_NONE,
                                        FLAG_ZPAD));
    // Precision beyond the limit saturates.
    pending_requests.push_back(make_req(64'd7, 1'b0, RADIX_DEC, 1'b0, 7'd0, 7'd63, FLAG_NONE));
    // Zero flag overruled by left justify, and by a precision.
    pending_requests.push_back(make_req(64'd9, 1'b0, RADIX_DEC, 1'b0, 7'd8, PREC_NONE,
                                        FLAG_ZPAD | FLAG_LEFT));
    pending_requests.push_back(make_req(64'd9, 1'b0, RADIX_DEC, 1'b0, 7'd8, 7'd3, FLAG_ZPAD));
    // Zero fill after sign and prefix.
    pending_requests.push_back(make_req(64'hABC, 1'b1, RADIX_HEX, 1'b0, 7'd20, PREC_NONE,
                                        FLAG_ZPAD | FLAG_ALT));
    // Sign priority.
    pending_requests.push_back(make_req(64'd5, 1'b1, RADIX_DEC, 1'b0, 7'd0, PREC_NONE,
                                        FLAG_SHOW_POS | FLAG_BLANK));
    pending_requests.push_back(make_req(64'd5, 1'b0, RADIX_DEC, 1'b0, 7'd0, PREC_NONE,
                                        FLAG_SHOW_POS | FLAG_BLANK));
    pending_requests.push_back(make_req(64'd5, 1'b0, RADIX_DEC, 1'b0, 7'd0, PREC_NONE,
                                        FLAG_BLANK));
    // Octal alternate form when precision zeros already lead.
    pending_requests.push_back(make_req(64'o17, 1'b0, RADIX_OCT, 1'b0, 7'd0, 7'd5, FLAG_ALT));
    // Most negative precision code also means none given.
    pending_requests.push_back(make_req(64'd123, 1'b0, RADIX_DEC, 1'b0, 7'd6, PREC_MOST_NEG,
                                        FLAG_ZPAD));
    // Widest text: width and precision at their limits with sign and prefix.
    pending_requests.push_back(make_req(64'h1, 1'b0, RADIX_HEX, 1'b1, 7'd64, 7'd60,
                                        FLAG_ALT | FLAG_SHOW_POS));
    pending_requests.push_back(make_req('0, 1'b0, RADIX_DEC, 1'b0, 7'd0, PREC_NONE, FLAG_NONE));

    // Random items; one stretch with no idling, and a few drain points.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      rq = random_req();
      if (i >= 150 && i < 200) begin
        rq.idle_before = 0;
        rq.calm = 1'b1;
      end
      rq.drain_first = (i % 120 == 0);
      pending_requests.push_back(rq);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Let the sender run dry, the text drain, then the block settle.
    while (pending_requests.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_text.size() != 0) begin
      $display("%0d characters never arrived", expected_text.size());
      error_count += expected_text.size();
    end

    $display("requests: %0d accepted, %0d produced no text", accepted_count, silent_count);
    $display("characters checked: %0d, errors: %0d", chars_checked, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/itpt_pkg.sv
rtl/itpt_digit_unit.sv
rtl/integer_to_padded_text.sv
dv/integer_to_padded_text_test.sv
